// ===== rtl/stk_pkg.sv =====
// stk_pkg: shared constants, command codes and controller/datapath link types
// for the sorted key table; no dependencies

package stk_pkg;

    // table geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 16;
    localparam int VAL_W   = 16;
    localparam int TOTAL_W = 7;
    localparam int ENTRY_W = KEY_W + VAL_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic latch;       // capture request, start search window
        logic rd_mid;      // read entry at window midpoint
        logic cmp;         // narrow window from read key
        logic clear_count; // empty the table
        logic flag_full;   // mark insert refused
        logic shift_rd;    // read entry below shift index
        logic shift_wr;    // move read entry up, step index down
        logic wr_pos;      // write key and value at search position
        logic inc_count;   // one more entry held
        logic out_load;    // load result register
    } stk_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic is_search;   // latched command is set or get
        logic is_get;
        logic is_clear;
        logic search_end;  // window closed
        logic hit;         // key found during search
        logic full;        // table holds CAPACITY entries
        logic shift_end;   // shift index reached insert position
        logic out_free;    // result register can take a result
    } stk_sts_t;

endpackage

// ===== rtl/stk_req_if.sv =====
// stk_req_if: request channel (command, key, value) with valid/ready
// depends on stk_pkg

interface stk_req_if;
    import stk_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// ===== rtl/stk_rsp_if.sv =====
// stk_rsp_if: result channel (found, result_value, status, entry_total)
// depends on stk_pkg

interface stk_rsp_if;
    import stk_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [VAL_W-1:0]   result_value;
    logic               status;
    logic [TOTAL_W-1:0] entry_total;

    modport source (output valid, output found, output result_value, output status,
                    output entry_total, input ready);
    modport sink   (input valid, input found, input result_value, input status,
                    input entry_total, output ready);
endinterface

// ===== rtl/stk_ram.sv =====
// stk_ram: generic single write, single read port ram with registered read
// no dependencies

module stk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/stk_ctrl.sv =====
// stk_ctrl: sequencing state machine for search, update, insert shift and result
// depends on stk_pkg

module stk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  stk_pkg::stk_sts_t  sts,
    output stk_pkg::stk_ctl_t  ctl
);
    import stk_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEARCH   = 3'd1;
    localparam logic [2:0] S_COMPARE  = 3'd2;
    localparam logic [2:0] S_RESOLVE  = 3'd3;
    localparam logic [2:0] S_SHIFT_WR = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                priority if (!sts.is_search)
                begin
                    ctl.clear_count = sts.is_clear;
                    state_next      = S_DONE;
                end
                else if (sts.search_end)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    ctl.rd_mid = 1'b1;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                ctl.cmp    = 1'b1;
                state_next = S_SEARCH;
            end
            S_RESOLVE:
            begin
                priority if (sts.is_get)
                begin
                    state_next = S_DONE;
                end
                else if (sts.hit)
                begin
                    ctl.wr_pos = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.full)
                begin
                    ctl.flag_full = 1'b1;
                    state_next    = S_DONE;
                end
                else if (sts.shift_end)
                begin
                    ctl.wr_pos    = 1'b1;
                    ctl.inc_count = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    ctl.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.shift_wr = 1'b1;
                state_next   = S_RESOLVE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/stk_datapath.sv =====
// stk_datapath: entry ram, search window, shift index, entry count and result register
// depends on stk_pkg and stk_ram

module stk_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stk_pkg::stk_ctl_t           ctl,
    output stk_pkg::stk_sts_t           sts,
    input  logic [stk_pkg::CMD_W-1:0]   req_command,
    input  logic [stk_pkg::KEY_W-1:0]   req_key,
    input  logic [stk_pkg::VAL_W-1:0]   req_value,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic                        rsp_found,
    output logic [stk_pkg::VAL_W-1:0]   rsp_result_value,
    output logic                        rsp_status,
    output logic [stk_pkg::TOTAL_W-1:0] rsp_entry_total
);
    import stk_pkg::*;

    // latched request payload
    logic [CMD_W-1:0]   cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;

    // search and shift state
    logic [CNT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   hi_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               hit_reg;
    logic               full_reg;
    logic [VAL_W-1:0]   hit_val_reg;

    // result register
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic               out_status_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   idx_m1;
    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // window midpoint and shift source index
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_m1 = idx_reg - CNT_W'(1);
    assign rd_key = ram_rdata[ENTRY_W-1:VAL_W];
    assign rd_val = ram_rdata[VAL_W-1:0];

    // ram port selection
    assign ram_re    = ctl.rd_mid || ctl.shift_rd;
    assign ram_raddr = ctl.rd_mid ? mid[IDX_W-1:0] : idx_m1[IDX_W-1:0];
    assign ram_we    = ctl.wr_pos || ctl.shift_wr;
    assign ram_waddr = ctl.shift_wr ? idx_reg[IDX_W-1:0] : lo_reg[IDX_W-1:0];
    assign ram_wdata = ctl.shift_wr ? ram_rdata : {key_reg, val_reg};

    stk_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // request payload capture
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg <= req_command;
            key_reg <= req_key;
            val_reg <= req_value;
        end
    end

    // search window, shift index and hit capture
    always_ff @(posedge clk)
    begin
        priority if (ctl.latch)
        begin
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            idx_reg <= count_reg;
        end
        else if (ctl.cmp)
        begin
            if (rd_key < key_reg)
            begin
                lo_reg <= mid + CNT_W'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        else if (ctl.shift_wr)
        begin
            idx_reg <= idx_m1;
        end
        if (ctl.cmp && (rd_key == key_reg))
        begin
            hit_val_reg <= rd_val;
        end
    end

    // control flags and entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hit_reg   <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            priority if (ctl.latch)
            begin
                hit_reg  <= 1'b0;
                full_reg <= 1'b0;
            end
            else if (ctl.cmp && (rd_key == key_reg))
            begin
                hit_reg <= 1'b1;
            end
            else if (ctl.flag_full)
            begin
                full_reg <= 1'b1;
            end
            priority if (ctl.clear_count)
            begin
                count_reg <= '0;
            end
            else if (ctl.inc_count)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // result register handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_found_reg  <= hit_reg;
            out_value_reg  <= ((cmd_reg == CMD_GET) && hit_reg) ? hit_val_reg : '0;
            out_status_reg <= full_reg;
            out_total_reg  <= TOTAL_W'(count_reg);
        end
    end

    // status to controller
    assign sts.is_search  = (cmd_reg == CMD_SET) || (cmd_reg == CMD_GET);
    assign sts.is_get     = (cmd_reg == CMD_GET);
    assign sts.is_clear   = (cmd_reg == CMD_CLEAR);
    assign sts.search_end = (lo_reg == hi_reg);
    assign sts.hit        = hit_reg;
    assign sts.full       = (count_reg >= CNT_W'(CAPACITY));
    assign sts.shift_end  = (idx_reg == lo_reg);
    assign sts.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid        = out_valid_reg;
    assign rsp_found        = out_found_reg;
    assign rsp_result_value = out_value_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_entry_total  = out_total_reg;
endmodule

// ===== rtl/sorted_key_table_unit.sv =====
// sorted_key_table_unit: top level of the sorted key table
// depends on stk_pkg, stk_req_if, stk_rsp_if, stk_ctrl, stk_datapath
//
//   channel  role    fields
//   -------  ------  -------------------------------------------
//   req      sink    command[1:0], key[15:0], value[15:0]
//   rsp      source  found, result_value[15:0], status, entry_total[6:0]
//
// one request at a time; a search reads the window midpoint on the single ram read
// port and narrows the window until it closes, with accept, window end check,
// resolve and result steps around it; an insert moves each entry above the insert
// position up one place (read then write); clear and unused codes skip the search
// reset clears count, flags and result valid; the entry ram needs no clearing pass
// a result waits in the output register while the next request is taken and
// worked on; that request then holds in its last step until the result moves

module sorted_key_table_unit (
    input  logic      clk,
    input  logic      rst_n,
    stk_req_if.sink   req,
    stk_rsp_if.source rsp
);
    import stk_pkg::*;

    stk_ctl_t ctl;
    stk_sts_t sts;

    // sequencing
    stk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // storage and result
    stk_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .req_command      (req.command),
        .req_key          (req.key),
        .req_value        (req.value),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_found        (rsp.found),
        .rsp_result_value (rsp.result_value),
        .rsp_status       (rsp.status),
        .rsp_entry_total  (rsp.entry_total)
    );
endmodule

// ===== rtl/stk_checker.sv =====
// stk_checker: port level assertions for sorted_key_table_unit, bound to the top
// depends on stk_pkg

module stk_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_found,
    input logic [stk_pkg::VAL_W-1:0]   rsp_result_value,
    input logic                        rsp_status,
    input logic [stk_pkg::TOTAL_W-1:0] rsp_entry_total
);
    import stk_pkg::*;

    // a stalled result transfer keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
            && $stable(rsp_entry_total) && $stable(rsp_found) && $stable(rsp_status))
        else $error("result changed while stalled");

    // count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_entry_total <= TOTAL_W'(CAPACITY)))
        else $error("entry total above capacity");

    // a refused insert comes only from a full table and a missing key
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |->
            !rsp_found && (rsp_result_value == '0) && (rsp_entry_total == TOTAL_W'(CAPACITY)))
        else $error("full status inconsistent");

    // a returned value needs a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_result_value != '0) |-> rsp_found)
        else $error("value returned without hit");
endmodule

bind sorted_key_table_unit stk_checker u_stk_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_found        (rsp.found),
    .rsp_result_value (rsp.result_value),
    .rsp_status       (rsp.status),
    .rsp_entry_total  (rsp.entry_total)
);

// ===== verif/stk_table_tracker.sv =====
// stk_table_tracker: watches the request and result channels of the sorted key table,
// keeps its own copy of the table to predict each result and compares field by field
// depends on stk_pkg, stk_req_if, stk_rsp_if

module stk_table_tracker (
    input  logic      clk,
    input  logic      rst_n,
    stk_req_if        req,
    stk_rsp_if        rsp,
    output int        fail_count,
    output int        waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import stk_pkg::*;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   result_value;
        logic               status;
        logic [TOTAL_W-1:0] entry_total;
    } table_result_t;

    // shadow table, ascending keys below held_count
    bit [KEY_W-1:0] held_keys [CAPACITY];
    bit [VAL_W-1:0] held_vals [CAPACITY];
    int             held_count = 0;

    table_result_t  pending_results [$];

    initial
    begin
        fail_count = 0;
        waiting    = 0;
    end

    // apply one command to the shadow table and return the result it causes
    function automatic table_result_t apply_table_command(
        input logic [CMD_W-1:0] cmd,
        input logic [KEY_W-1:0] k,
        input logic [VAL_W-1:0] v
    );
        table_result_t r;
        int            lo;
        int            hi;
        int            mid;
        int            pos;
        bit            hit;

        r  = '0;
        lo = 0;
        hi = held_count;
        // binary search for the first key not below k
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (held_keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        pos = lo;
        hit = (pos < held_count) && (held_keys[pos] == k);

        unique case (cmd)
            CMD_SET:
            begin
                if (hit)
                begin
                    r.found        = 1'b1;
                    held_vals[pos] = v;
                end
                else if (held_count >= CAPACITY)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    // open a slot at the sorted position
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_keys[i] = held_keys[i-1];
                        held_vals[i] = held_vals[i-1];
                    end
                    held_keys[pos] = k;
                    held_vals[pos] = v;
                    held_count++;
                end
            end
            CMD_GET:
            begin
                if (hit)
                begin
                    r.found        = 1'b1;
                    r.result_value = held_vals[pos];
                end
            end
            CMD_CLEAR:
            begin
                held_count = 0;
            end
            default:
            begin
                // unused code leaves the table alone
            end
        endcase
        r.entry_total = TOTAL_W'(held_count);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result transfer is compared before a request transfer on the same edge is predicted
    always @(posedge clk)
    begin
        table_result_t exp_r;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display({"%0t: result transfer with none expected: ",
                              "found %0d value %0d status %0d total %0d"},
                             $time, rsp.found, rsp.result_value, rsp.status, rsp.entry_total);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("found", exp_r.found, rsp.found);
                    check_field("result_value", exp_r.result_value, rsp.result_value);
                    check_field("status", exp_r.status, rsp.status);
                    check_field("entry_total", exp_r.entry_total, rsp.entry_total);
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(apply_table_command(req.command, req.key, req.value));
            waiting = pending_results.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// testbench: stimulus and verdict for sorted_key_table_unit; directed lookups and inserts,
// then random fill and mixed sessions under three idle patterns
// depends on stk_pkg, stk_req_if, stk_rsp_if, sorted_key_table_unit, stk_table_tracker

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import stk_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               PHASE_ITEMS = 530;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   waiting;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   items_sent;

    stk_req_if req_bus ();
    stk_rsp_if rsp_bus ();

    sorted_key_table_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    stk_table_tracker tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_bus),
        .rsp        (rsp_bus),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(50_000_000);
        $display("sorted_key_table_unit: mismatch");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.command <= cmd;
        req_bus.key     <= k;
        req_bus.value   <= v;
        do
            @(posedge clk);
        while (!req_bus.ready);
        items_sent++;
    endtask

    // edges of the key and value ranges, overwrite, misses, clear and the unused code
    task automatic run_directed();
        send_request(CMD_GET,    16'h0000, 16'h0000);
        send_request(CMD_SET,    16'h1234, 16'hFFFF);
        send_request(CMD_SET,    16'h0000, 16'h0000);
        send_request(CMD_SET,    16'hFFFF, 16'hA5A5);
        send_request(CMD_SET,    16'h8000, 16'h5A5A);
        send_request(CMD_GET,    16'h0000, 16'hFFFF);
        send_request(CMD_GET,    16'hFFFF, 16'h0000);
        send_request(CMD_GET,    16'h1234, 16'h0000);
        send_request(CMD_GET,    16'h1235, 16'h0000);
        send_request(CMD_GET,    16'h7FFF, 16'h0000);
        send_request(CMD_SET,    16'h1234, 16'h0001);
        send_request(CMD_GET,    16'h1234, 16'h0000);
        send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        send_request(CMD_GET,    16'h8000, 16'h0000);
        send_request(CMD_CLEAR,  16'hFFFF, 16'hFFFF);
        send_request(CMD_GET,    16'h1234, 16'h0000);
        send_request(CMD_SET,    16'h0001, 16'hFFFF);
        send_request(CMD_SET,    16'hFFFE, 16'h0000);
        send_request(CMD_UNUSED, 16'h0000, 16'h0000);
        send_request(CMD_GET,    16'hFFFE, 16'h0000);
        send_request(CMD_CLEAR,  16'h0000, 16'h0000);
    endtask

    // clear, then insert past capacity in random, ascending or descending key order
    task automatic run_fill_session();
        bit [KEY_W-1:0] new_keys [$];
        bit [KEY_W-1:0] used_keys [$];
        int             order;
        int             n;
        int             r;

        send_request(CMD_CLEAR, 16'($urandom), 16'($urandom));
        n = CAPACITY + $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
            new_keys.push_back(16'($urandom));
        order = $urandom_range(0, 2);
        if (order == 1)
            new_keys.sort();
        else if (order == 2)
            new_keys.rsort();
        foreach (new_keys[i])
        begin
            send_request(CMD_SET, new_keys[i], 16'($urandom));
            used_keys.push_back(new_keys[i]);
            r = $urandom_range(0, 99);
            if (r < 30)
                send_request(CMD_GET, used_keys[$urandom_range(0, used_keys.size() - 1)],
                             16'($urandom));
            else if (r < 40)
                send_request(CMD_SET, used_keys[$urandom_range(0, used_keys.size() - 1)],
                             16'($urandom));
            else if (r < 45)
                send_request(CMD_GET, 16'($urandom), 16'($urandom));
        end
        // lookups in the full table
        for (int i = 0; i < 8; i++)
            send_request(CMD_GET, used_keys[$urandom_range(0, used_keys.size() - 1)],
                         16'($urandom));
    endtask

    // sets and gets over a small key pool with occasional noise
    task automatic run_mixed_session();
        bit [KEY_W-1:0] pool [$];
        bit [KEY_W-1:0] k;
        int             pool_size;
        int             len;
        int             r;

        pool_size = $urandom_range(1, 80);
        for (int i = 0; i < pool_size; i++)
        begin
            r = $urandom_range(0, 19);
            pool.push_back(r == 0 ? 16'h0000 : (r == 1 ? 16'hFFFF : 16'($urandom)));
        end
        len = $urandom_range(10, 60);
        for (int i = 0; i < len; i++)
        begin
            k = pool[$urandom_range(0, pool_size - 1)];
            r = $urandom_range(0, 99);
            if (r < 50)
                send_request(CMD_SET, k, 16'($urandom));
            else if (r < 80)
                send_request(CMD_GET, k, 16'($urandom));
            else if (r < 90)
                send_request(CMD_GET, 16'($urandom), 16'($urandom));
            else if (r < 95)
                send_request(CMD_UNUSED, 16'($urandom), 16'($urandom));
            else if (r < 98)
                send_request(CMD_SET, 16'($urandom), 16'($urandom));
            else
                send_request(CMD_CLEAR, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_random_phase(input int target);
        int start;
        bit first;

        start = items_sent;
        first = 1'b1;
        while (items_sent - start < target)
        begin
            if (first || $urandom_range(0, 3) == 0)
                run_fill_session();
            else
                run_mixed_session();
            first = 1'b0;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        req_bus.valid   <= 1'b0;
        req_bus.command <= CMD_SET;
        req_bus.key     <= '0;
        req_bus.value   <= '0;
        rst_n           <= 1'b0;
        items_sent    = 0;
        send_idle_pct = 7;
        recv_idle_pct = 45;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 45;
        recv_idle_pct = 7;
        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);
        req_bus.valid <= 1'b0;

        // drain outstanding results, then let the block settle
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (200) @(posedge clk);

        if (fail_count == 0 && waiting == 0)
            $display("sorted_key_table_unit: match");
        else
            $display("sorted_key_table_unit: mismatch");
        $finish;
    end

endmodule
